>>> src/unsigned_infix_expression_evaluator_unit_assert.svh
// Assertion macros for the expression evaluator.
`ifndef UNSIGNED_INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define UNSIGNED_INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
// Assert that an implication holds at every edge outside reset.
`define UIE_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define UIE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

>>> src/uie_pkg.sv
// ----------------------------------------------------------------------------
// uie_pkg
// Types and codes shared by the expression evaluator.
// ----------------------------------------------------------------------------
package uie_pkg;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_LPAR = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOKENS    = 2'd1;
	localparam logic [1:0] ST_DIVZERO   = 2'd2;
	localparam logic [1:0] ST_MALFORMED = 2'd3;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	typedef logic [2:0] op_t;
	typedef logic [1:0] status_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_beat_t;

	typedef struct packed {
		logic [63:0] value;
		status_t     status;
	} result_beat_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_rsp_t;

	function automatic logic [1:0] prec(input op_t op);
		logic [1:0] p;
		p = 2'd0;
		if (op == OP_ADD || op == OP_SUB) p = 2'd1;
		if (op == OP_MUL || op == OP_DIV) p = 2'd2;
		return p;
	endfunction
endpackage

>>> src/uie_stream_if.sv
// ----------------------------------------------------------------------------
// uie_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface uie_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/uie_alu.sv
// ----------------------------------------------------------------------------
// uie_alu
// Shared multi-cycle unit: add/sub registered straight from the request,
// shift-add multiply and restoring divide at one bit per cycle.
// ----------------------------------------------------------------------------
module uie_alu #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  uie_pkg::alu_req_t      req,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output logic [VALUE_WIDTH-1:0] result,
	output uie_pkg::alu_rsp_t      rsp
);
	import uie_pkg::*;
	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic              busy_q;
	op_t               op_q;
	logic [CW-1:0]     cnt_q;
	logic [VALUE_WIDTH-1:0] acc_q, x_q, y_q, res_q;
	logic              dz_q, done_q;
	logic [VALUE_WIDTH:0]   rem_sh;
	logic [VALUE_WIDTH:0]   rem_sub;

	assign rem_sh  = {acc_q, x_q[VALUE_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			dz_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q  <= req.op;
				x_q   <= a;
				y_q   <= b;
				acc_q <= '0;
				dz_q  <= 1'b0;
				cnt_q <= CW'(VALUE_WIDTH);
				if (req.op == OP_ADD) begin
					res_q  <= a + b;
					done_q <= 1'b1;
				end else if (req.op == OP_SUB) begin
					res_q  <= a - b;
					done_q <= 1'b1;
				end else if (req.op == OP_DIV && b == '0) begin
					res_q  <= '0;
					dz_q   <= 1'b1;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (op_q == OP_MUL) begin
					if (x_q[0]) acc_q <= acc_q + y_q;
					x_q <= x_q >> 1;
					y_q <= y_q << 1;
					res_q <= x_q[0] ? acc_q + y_q : acc_q;
				end else begin
					if (!rem_sub[VALUE_WIDTH]) acc_q <= rem_sub[VALUE_WIDTH-1:0];
					else acc_q <= rem_sh[VALUE_WIDTH-1:0];
					x_q <= {x_q[VALUE_WIDTH-2:0], ~rem_sub[VALUE_WIDTH]};
					res_q <= {x_q[VALUE_WIDTH-2:0], ~rem_sub[VALUE_WIDTH]};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign result       = res_q;
	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
endmodule

>>> src/unsigned_infix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// unsigned_infix_expression_evaluator_unit
// Character-serial evaluator of unsigned infix expressions.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one ASCII character per beat with a last flag; the beat
//   marked last closes the expression. out carries one beat per expression:
//   value and status (0 ok, 1 too many tokens, 2 divide by zero, 3 malformed).
//   Value is 0 whenever status is not ok.
// Timing:
//   A digit or ignored character passes S_IDLE and S_CHAR, '(' adds S_RDT,
//   any other operator or ')' adds S_RDT and S_LOOP plus one reduction per
//   operator it pops. A reduction runs S_POPB, S_POPA, S_GO, S_WAIT, S_RDT
//   and back to S_LOOP; for * and / S_WAIT lasts while the shared ALU iterates
//   one bit per cycle. The last beat adds a flush through S_FIN, S_RDT,
//   S_LOOP, S_RD0 and S_OUT plus its reductions.
// Reset:
//   arst_n clears all control state; stacks need no clearing as every pop
//   is guarded by its count.
// Stall:
//   The result waits in an output register. The next expression is taken
//   meanwhile and held at its final step until the waiting beat is taken.
// ----------------------------------------------------------------------------
module unsigned_infix_expression_evaluator_unit #(
	parameter int MAX_ELEMENTS = 64,
	parameter int VALUE_WIDTH  = 64
) (
	input  logic clk,
	input  logic arst_n,
	uie_stream_if.sink   in_ch,
	uie_stream_if.source out
);
	import uie_pkg::*;
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [VALUE_WIDTH-1:0] VMAX = '1;
	localparam logic [VALUE_WIDTH-1:0] SAT_LIM = VMAX / 10;
	localparam logic [3:0] SAT_REM = 4'(VMAX % 10);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHAR  = 4'd1;
	localparam logic [3:0] S_LOOP  = 4'd2;
	localparam logic [3:0] S_POPB  = 4'd3;
	localparam logic [3:0] S_POPA  = 4'd4;
	localparam logic [3:0] S_GO    = 4'd5;
	localparam logic [3:0] S_WAIT  = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;
	localparam logic [3:0] S_RD0   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;
	localparam logic [3:0] S_RDT   = 4'd10;

	logic [3:0] state_q;
	logic [7:0] ch_q;
	logic       last_q;
	op_t        pend_q;
	logic       fin_q;
	logic [CW-1:0] opnd_cnt_q, oper_cnt_q, tok_q;
	logic [VALUE_WIDTH-1:0] num_q;
	logic       in_num_q, expect_q;
	status_t    err_q;
	logic [VALUE_WIDTH-1:0] a_q, b_q;
	op_t        rop_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	status_t    res_st_q;
	logic       out_valid_q;

	logic [VALUE_WIDTH-1:0] opnd_mem [MAX_ELEMENTS];
	op_t        oper_mem [MAX_ELEMENTS];
	logic [VALUE_WIDTH-1:0] opnd_rd_q;
	op_t        top_q;

	alu_req_t   alu_req;
	alu_rsp_t   alu_rsp;
	logic [VALUE_WIDTH-1:0] alu_res;

	logic       opnd_we;
	logic [AW-1:0] opnd_wa;
	logic [VALUE_WIDTH-1:0] opnd_wd;
	logic       oper_we;
	logic [AW-1:0] oper_wa;
	op_t        oper_wd;
	logic [AW-1:0] opnd_ra, oper_ra;

	logic       is_digit;
	logic [3:0] dig;
	logic [VALUE_WIDTH-1:0] num_next;

	logic       closed;
	logic       pushing;
	logic       loop_reduce;

	assign is_digit = ch_q >= CH_0 && ch_q <= CH_9;
	assign dig      = 4'(ch_q - CH_0);
	always_comb begin
		if (num_q > SAT_LIM || (num_q == SAT_LIM && dig > SAT_REM))
			num_next = VMAX;
		else
			num_next = (num_q << 3) + (num_q << 1) + VALUE_WIDTH'(dig);
	end

	uie_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
		.clk(clk), .arst_n(arst_n), .req(alu_req), .a(a_q), .b(b_q),
		.result(alu_res), .rsp(alu_rsp)
	);

	always_ff @(posedge clk) begin
		if (opnd_we) opnd_mem[opnd_wa] <= opnd_wd;
		if (oper_we) oper_mem[oper_wa] <= oper_wd;
		opnd_rd_q <= opnd_mem[opnd_ra];
		top_q     <= oper_mem[oper_ra];
	end

	assign in_ch.ready = state_q == S_IDLE;
	assign out.valid   = out_valid_q;
	assign out.data    = {64'(res_val_q), res_st_q};

	always_comb begin
		loop_reduce = 1'b0;
		pushing = 1'b0;
		if (state_q == S_LOOP && err_q == ST_OK) begin
			if (oper_cnt_q != '0 && top_q != OP_LPAR &&
					(fin_q || pend_q == OP_LPAR || prec(top_q) >= prec(pend_q)))
				loop_reduce = 1'b1;
			else if (!fin_q && pend_q != OP_LPAR && oper_cnt_q < CW'(MAX_ELEMENTS))
				pushing = 1'b1;
		end
	end

	always_comb begin
		opnd_we = 1'b0;
		opnd_wa = opnd_cnt_q[AW-1:0];
		opnd_wd = num_q;
		oper_we = 1'b0;
		oper_wa = oper_cnt_q[AW-1:0];
		oper_wd = pend_q;
		opnd_ra = AW'(opnd_cnt_q - 1'b1);
		oper_ra = AW'(oper_cnt_q - 1'b1);
		alu_req.start = state_q == S_GO;
		alu_req.op    = rop_q;
		closed = 1'b0;
		if (state_q == S_CHAR && err_q == ST_OK && !is_digit && in_num_q &&
				opnd_cnt_q < CW'(MAX_ELEMENTS)) begin
			opnd_we = 1'b1;
			closed = 1'b1;
		end
		if (state_q == S_FIN && !fin_q && err_q == ST_OK && in_num_q &&
				opnd_cnt_q < CW'(MAX_ELEMENTS)) begin
			opnd_we = 1'b1;
		end
		if (state_q == S_WAIT && alu_rsp.done && !alu_rsp.div_zero &&
				opnd_cnt_q < CW'(MAX_ELEMENTS)) begin
			opnd_we = 1'b1;
			opnd_wd = alu_res;
		end
		if (state_q == S_POPB) opnd_ra = AW'(opnd_cnt_q - 2'd2);
		if (state_q == S_RD0 || state_q == S_FIN || state_q == S_OUT) opnd_ra = '0;
		if (state_q == S_RDT) oper_ra = AW'(oper_cnt_q - 1'b1);
		if (state_q == S_RDT && ch_q == CH_LPAR && !fin_q) begin
			oper_we = 1'b1;
		end
		if (state_q == S_LOOP && pushing) begin
			oper_we = 1'b1;
		end
	end

	// pend_q == OP_LPAR in S_LOOP stands for a closing bracket.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			opnd_cnt_q  <= '0;
			oper_cnt_q  <= '0;
			tok_q       <= '0;
			in_num_q    <= 1'b0;
			expect_q    <= 1'b1;
			err_q       <= ST_OK;
			num_q       <= '0;
			out_valid_q <= 1'b0;
			fin_q       <= 1'b0;
		end else begin
			if (out.valid && out.ready && state_q != S_OUT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						ch_q    <= in_ch.data.ch;
						last_q  <= in_ch.data.last;
						fin_q   <= 1'b0;
						state_q <= S_CHAR;
					end
				end
				S_CHAR: begin
					state_q <= last_q ? S_FIN : S_IDLE;
					if (err_q == ST_OK) begin
						if (is_digit) begin
							if (in_num_q) num_q <= num_next;
							else if (tok_q >= CW'(MAX_ELEMENTS)) err_q <= ST_TOKENS;
							else begin
								tok_q <= tok_q + 1'b1;
								if (!expect_q) err_q <= ST_MALFORMED;
								else begin
									in_num_q <= 1'b1;
									num_q    <= VALUE_WIDTH'(dig);
									expect_q <= 1'b0;
								end
							end
						end else begin
							logic err_c;
							err_c = 1'b0;
							if (in_num_q) begin
								in_num_q <= 1'b0;
								num_q    <= '0;
								if (closed) opnd_cnt_q <= opnd_cnt_q + 1'b1;
								else begin
									err_q <= ST_TOKENS;
									err_c = 1'b1;
								end
							end
							if (!err_c && (ch_q == CH_PLUS || ch_q == CH_MINUS ||
									ch_q == CH_STAR || ch_q == CH_SLASH ||
									ch_q == CH_LPAR || ch_q == CH_RPAR)) begin
								if (tok_q >= CW'(MAX_ELEMENTS)) err_q <= ST_TOKENS;
								else begin
									tok_q <= tok_q + 1'b1;
									if (ch_q == CH_LPAR) begin
										if (!expect_q) err_q <= ST_MALFORMED;
										else if (oper_cnt_q >= CW'(MAX_ELEMENTS))
											err_q <= ST_TOKENS;
										else begin
											pend_q <= OP_LPAR;
											state_q <= S_RDT;
										end
									end else if (expect_q) err_q <= ST_MALFORMED;
									else begin
										case (ch_q)
											CH_PLUS:  pend_q <= OP_ADD;
											CH_MINUS: pend_q <= OP_SUB;
											CH_STAR:  pend_q <= OP_MUL;
											CH_SLASH: pend_q <= OP_DIV;
											default:  pend_q <= OP_LPAR;
										endcase
										state_q <= S_RDT;
									end
								end
							end
						end
					end
				end
				S_RDT: begin
					// '(' pushes directly; others go through the loop.
					if (ch_q == CH_LPAR && !fin_q) begin
						oper_cnt_q <= oper_cnt_q + 1'b1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end else
						state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (err_q != ST_OK) state_q <= fin_q ? S_OUT : (last_q ? S_FIN : S_IDLE);
					else if (loop_reduce) begin
						if (opnd_cnt_q < CW'(2)) err_q <= ST_MALFORMED;
						else begin
							rop_q <= top_q;
							oper_cnt_q <= oper_cnt_q - 1'b1;
							state_q <= S_POPB;
						end
					end else if (fin_q) begin
						if (oper_cnt_q != '0) err_q <= ST_MALFORMED;
						else if (opnd_cnt_q != CW'(1)) err_q <= ST_MALFORMED;
						state_q <= S_RD0;
					end else if (pend_q == OP_LPAR) begin
						if (oper_cnt_q == '0) err_q <= ST_MALFORMED;
						else oper_cnt_q <= oper_cnt_q - 1'b1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end else begin
						if (pushing) begin
							oper_cnt_q <= oper_cnt_q + 1'b1;
							expect_q <= 1'b1;
						end else err_q <= ST_TOKENS;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_POPB: begin
					b_q <= opnd_rd_q;
					state_q <= S_POPA;
				end
				S_POPA: begin
					a_q <= opnd_rd_q;
					opnd_cnt_q <= opnd_cnt_q - 2'd2;
					state_q <= S_GO;
				end
				S_GO: state_q <= S_WAIT;
				S_WAIT: begin
					if (alu_rsp.done) begin
						if (alu_rsp.div_zero) err_q <= ST_DIVZERO;
						else if (opnd_we) opnd_cnt_q <= opnd_cnt_q + 1'b1;
						else err_q <= ST_TOKENS;
						state_q <= S_RDT;
					end
				end
				S_FIN: begin
					if (fin_q || err_q != ST_OK) state_q <= S_OUT;
					else if (in_num_q) begin
						in_num_q <= 1'b0;
						num_q <= '0;
						if (opnd_cnt_q < CW'(MAX_ELEMENTS)) begin
							opnd_cnt_q <= opnd_cnt_q + 1'b1;
						end else err_q <= ST_TOKENS;
						fin_q <= 1'b1;
						state_q <= S_RDT;
					end else begin
						if (expect_q) err_q <= ST_MALFORMED;
						fin_q <= 1'b1;
						state_q <= S_RDT;
					end
				end
				S_RD0: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || (out.valid && out.ready)) begin
						res_st_q    <= err_q;
						res_val_q   <= (err_q == ST_OK) ? opnd_rd_q : '0;
						out_valid_q <= 1'b1;
						opnd_cnt_q  <= '0;
						oper_cnt_q  <= '0;
						tok_q       <= '0;
						in_num_q    <= 1'b0;
						expect_q    <= 1'b1;
						err_q       <= ST_OK;
						num_q       <= '0;
						fin_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> src/uie_checker.sv
// ----------------------------------------------------------------------------
// uie_checker
// Port-level checks of the expression evaluator.
// ----------------------------------------------------------------------------
`include "unsigned_infix_expression_evaluator_unit_assert.svh"
module uie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_value,
	input logic [1:0]  out_status
);
	import uie_pkg::*;
	`UIE_ASSERT(a_err_zero, out_valid && out_status != ST_OK, out_value == 64'd0, "value not zero on error")
	`UIE_ASSERT_NEXT(a_no_back, in_valid && in_ready, !in_ready, "ready held after beat")
	`UIE_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_last, !out_valid || !in_ready, "last beat overlapped")
	`UIE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status), "result beat dropped or changed while stalled")
endmodule

bind unsigned_infix_expression_evaluator_unit uie_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.data.last),
	.out_valid(out.valid), .out_ready(out.ready),
	.out_value(out.data.value), .out_status(out.data.status)
);
